[sv/ctbd_pkg.sv]
// Package for the channel trailer and bunch decoder.
// Holds the parser state type, phase and error codes and the word constants.
// No dependencies.
package ctbd_pkg;

    localparam int unsigned MAX_PAYLOAD_WORDS = 65535;

    localparam logic [9:0] FILL_WORD = 10'h2AA;
    localparam logic [3:0] MARKER    = 4'hA;

    // parser phases
    localparam logic [2:0] PH_FILL   = 3'd0;
    localparam logic [2:0] PH_TW1    = 3'd1;
    localparam logic [2:0] PH_TW2    = 3'd2;
    localparam logic [2:0] PH_TW3    = 3'd3;
    localparam logic [2:0] PH_HEAD   = 3'd4;
    localparam logic [2:0] PH_TIME   = 3'd5;
    localparam logic [2:0] PH_SAMPLE = 3'd6;
    localparam logic [2:0] PH_WAIT   = 3'd7;

    // result kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_ERROR  = 1'b1;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_FILL   = 3'd1;
    localparam logic [2:0] ERR_SHORT     = 3'd2;
    localparam logic [2:0] ERR_MARKER1   = 3'd3;
    localparam logic [2:0] ERR_MARKER2   = 3'd4;
    localparam logic [2:0] ERR_SIZE      = 3'd5;
    localparam logic [2:0] ERR_BUNCH     = 3'd6;
    localparam logic [2:0] ERR_AMPLITUDE = 3'd7;

    typedef struct packed {
        logic [2:0]  phase;
        logic        fill_seen;
        logic        hunting;
        logic [9:0]  words_remaining;
        logic [11:0] address;
        logic [1:0]  pad_left;
        logic [9:0]  bunch_left;
        logic [9:0]  time_val;
        logic [9:0]  chan_size;
        logic        first_sample;
    } parse_state_t;

endpackage

[sv/channel_trailer_bunch_decoder.sv]
// Channel trailer and bunch decoder: one registered parse step per payload word.
// Depends on ctbd_pkg.
//
// Usage
//   Input channel (item_valid / item_stall) carries one payload word per beat,
//   read from the payload end backward, with the count of words still unread
//   and a new_payload flag that restarts the trailer search.
//   Result channel (res_valid / res_stall) carries at most one result per input
//   beat: a sample (kind 0) with address, time bin, amplitude and bunch start
//   flag, or an error report (kind 1) with its error code.
//   A taken beat is held in the input register, parsed out of it, and its
//   result, if any, is written into the result register.
//   Throughput: one beat per cycle unless res_stall holds a result; the parse step
//   is a single combinational pass between the input and result registers.
//   Stall: while a result waits under res_stall, one more beat is taken into
//   the input register; item_stall rises only when both stages are full.
//   Reset: both stages empty, parser back to the fill search with all
//   counters, address and channel size cleared.
//   Words that produce no result still advance the parser and leave no beat.
module channel_trailer_bunch_decoder
    import ctbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_stall,
    input  logic [9:0]  word,
    input  logic [15:0] words_left,
    input  logic        new_payload,

    output logic        res_valid,
    input  logic        res_stall,
    output logic        kind,
    output logic [11:0] hw_address,
    output logic [9:0]  time_bin,
    output logic [9:0]  signal,
    output logic        bunch_start,
    output logic [9:0]  channel_size,
    output logic [2:0]  error_code
);

    localparam logic [15:0] WL_CAP = (MAX_PAYLOAD_WORDS > 65535) ? 16'hFFFF
                                     : 16'(MAX_PAYLOAD_WORDS);

    // ------------------------------------------------------------------
    // parse helpers
    // ------------------------------------------------------------------
    function automatic parse_state_t to_search(input parse_state_t s);
        parse_state_t r;
        r                 = s;
        r.phase           = PH_FILL;
        r.fill_seen       = 1'b0;
        r.hunting         = 1'b0;
        r.words_remaining = '0;
        r.bunch_left      = '0;
        r.pad_left        = '0;
        return r;
    endfunction

    function automatic parse_state_t trailer_first(input parse_state_t s,
                                                   input logic [9:0] w,
                                                   input logic [15:0] wl,
                                                   output logic [2:0] err);
        parse_state_t r;
        r           = s;
        r.fill_seen = 1'b0;
        r.hunting   = 1'b0;
        err         = ERR_NONE;
        if (wl < 16'd2)
        begin
            r       = to_search(r);
            r.phase = PH_WAIT;
            err     = ERR_SHORT;
        end
        else
        begin
            r.words_remaining = {w[5:0], 4'b0000};
            if (w[9:6] != MARKER)
            begin
                r   = to_search(r);
                err = ERR_MARKER1;
            end
            else
            begin
                r.phase = PH_TW2;
            end
        end
        return r;
    endfunction

    function automatic parse_state_t fill_search(input parse_state_t s,
                                                 input logic [9:0] w,
                                                 input logic [15:0] wl,
                                                 output logic [2:0] err);
        parse_state_t r;
        r   = s;
        err = ERR_NONE;
        if (r.hunting)
        begin
            if (w == FILL_WORD)
            begin
                r.hunting = 1'b0;
                r.phase   = PH_TW1;
            end
            else if (wl <= 16'd2)
            begin
                r.hunting = 1'b0;
                r.phase   = PH_WAIT;
            end
        end
        else if (w == FILL_WORD)
        begin
            r.fill_seen = 1'b1;
            if (wl == 16'd0)
            begin
                r.phase = PH_WAIT;
                err     = ERR_SHORT;
            end
        end
        else if (r.fill_seen)
        begin
            r = trailer_first(r, w, wl, err);
        end
        else
        begin
            if (wl > 16'd2)
                r.hunting = 1'b1;
            else
                r.phase = PH_WAIT;
            err = ERR_NO_FILL;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic         in_valid_reg;
    logic [9:0]   word_reg;
    logic [15:0]  words_left_reg;
    logic         new_payload_reg;
    logic         in_valid_next;

    parse_state_t state_reg;
    parse_state_t state_next;

    logic         advance;
    logic         take_in;
    logic [15:0]  wl_c;
    logic [2:0]   err_c;
    logic         sample_c;
    logic [9:0]   s_time_c;
    logic         s_start_c;

    logic         res_valid_reg;
    logic         res_valid_next;
    logic         kind_reg;
    logic [11:0]  hw_address_reg;
    logic [9:0]   time_bin_reg;
    logic [9:0]   signal_reg;
    logic         bunch_start_reg;
    logic [9:0]   channel_size_reg;
    logic [2:0]   error_code_reg;

    assign advance    = in_valid_reg && (!res_valid_reg || !res_stall);
    assign item_stall = in_valid_reg && !advance;
    assign take_in    = item_valid && !item_stall;

    always_comb
    begin
        if (take_in)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    // hold the payload while the beat waits
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            word_reg        <= word;
            words_left_reg  <= words_left;
            new_payload_reg <= new_payload;
        end
    end

    // ------------------------------------------------------------------
    // parse step
    // ------------------------------------------------------------------
    assign wl_c = (words_left_reg > WL_CAP) ? WL_CAP : words_left_reg;

    always_comb
    begin
        state_next = state_reg;
        err_c      = ERR_NONE;
        sample_c   = 1'b0;
        s_time_c   = '0;
        s_start_c  = 1'b0;

        if (new_payload_reg)
        begin
            state_next           = to_search(state_next);
            state_next.chan_size = '0;
        end

        case (state_next.phase)
            PH_FILL:
            begin
                state_next = fill_search(state_next, word_reg, wl_c, err_c);
            end
            PH_TW1:
            begin
                state_next = trailer_first(state_next, word_reg, wl_c, err_c);
            end
            PH_TW2:
            begin
                state_next.address = {word_reg[1:0], 10'b0};
                if (word_reg[5:2] != MARKER)
                begin
                    state_next = to_search(state_next);
                    err_c      = ERR_MARKER2;
                end
                else
                begin
                    state_next.words_remaining = state_next.words_remaining
                                                 | {6'b0, word_reg[9:6]};
                    state_next.chan_size = state_next.words_remaining;
                    if ({6'b0, state_next.words_remaining} >= wl_c)
                    begin
                        state_next = to_search(state_next);
                        err_c      = ERR_SIZE;
                    end
                    else
                    begin
                        state_next.phase = PH_TW3;
                    end
                end
            end
            PH_TW3:
            begin
                state_next.address = state_next.address | {2'b00, word_reg};
                if (state_next.words_remaining == '0)
                begin
                    state_next = to_search(state_next);
                end
                else
                begin
                    // pad up to a multiple of four words
                    state_next.pad_left = 2'd0 - state_next.words_remaining[1:0];
                    state_next.phase    = PH_HEAD;
                end
            end
            PH_HEAD:
            begin
                if (state_next.pad_left != 2'd0)
                begin
                    state_next.pad_left = state_next.pad_left - 2'd1;
                end
                else if (state_next.words_remaining <= 10'd2)
                begin
                    // report, then treat the same word as a search word
                    state_next = to_search(state_next);
                    state_next = fill_search(state_next, word_reg, wl_c, err_c);
                    err_c      = ERR_BUNCH;
                end
                else if (word_reg < 10'd2
                         || (word_reg - 10'd2) > state_next.words_remaining)
                begin
                    state_next = to_search(state_next);
                    err_c      = ERR_BUNCH;
                end
                else
                begin
                    state_next.bunch_left      = word_reg - 10'd2;
                    state_next.words_remaining = state_next.words_remaining - 10'd1;
                    state_next.phase           = PH_TIME;
                end
            end
            PH_TIME:
            begin
                state_next.time_val        = word_reg;
                state_next.first_sample    = 1'b1;
                state_next.words_remaining = state_next.words_remaining - 10'd1;
                if (state_next.words_remaining == '0)
                    state_next = to_search(state_next);
                else
                    state_next.phase = PH_SAMPLE;
            end
            PH_SAMPLE:
            begin
                sample_c                   = 1'b1;
                s_time_c                   = state_next.time_val;
                s_start_c                  = state_next.first_sample;
                state_next.first_sample    = 1'b0;
                state_next.time_val        = state_next.time_val - 10'd1;
                state_next.bunch_left      = state_next.bunch_left - 10'd1;
                state_next.words_remaining = state_next.words_remaining - 10'd1;
                if (state_next.words_remaining == '0)
                    state_next = to_search(state_next);
                else if (state_next.bunch_left == '0)
                    state_next.phase = PH_HEAD;
            end
            default:
            begin
                // wait for the next payload
            end
        endcase

        // payload exhausted: park until new_payload
        if (wl_c == 16'd0 && state_next.phase != PH_WAIT)
        begin
            state_next       = to_search(state_next);
            state_next.phase = PH_WAIT;
        end
    end

    // an all-zero state is the fill search
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_comb
    begin
        if (advance && (sample_c || err_c != ERR_NONE))
            res_valid_next = 1'b1;
        else if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && (sample_c || err_c != ERR_NONE))
        begin
            hw_address_reg   <= state_next.address;
            channel_size_reg <= state_next.chan_size;
            if (sample_c)
            begin
                kind_reg        <= KIND_SAMPLE;
                time_bin_reg    <= s_time_c;
                signal_reg      <= word_reg;
                bunch_start_reg <= s_start_c;
                error_code_reg  <= ERR_NONE;
            end
            else
            begin
                kind_reg        <= KIND_ERROR;
                time_bin_reg    <= '0;
                signal_reg      <= '0;
                bunch_start_reg <= 1'b0;
                error_code_reg  <= err_c;
            end
        end
    end

    assign res_valid    = res_valid_reg;
    assign kind         = kind_reg;
    assign hw_address   = hw_address_reg;
    assign time_bin     = time_bin_reg;
    assign signal       = signal_reg;
    assign bunch_start  = bunch_start_reg;
    assign channel_size = channel_size_reg;
    assign error_code   = error_code_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        item_stall |-> (res_valid && res_stall))
        else $error("input stalled while result stage free");

    a_kind_matches_code: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
        else $error("result kind and error code disagree");

    a_error_fields_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res_valid && kind == KIND_ERROR)
            |-> (time_bin == '0 && signal == '0 && !bunch_start
                 && error_code != ERR_AMPLITUDE))
        else $error("error report carries sample fields");

    a_payload_end_parks: assert property (
        @(posedge clk) disable iff (!rst_n)
        (advance && wl_c == 16'd0) |=> (state_reg.phase == PH_WAIT))
        else $error("parser not parked after last payload word");

endmodule
